/* rtl/pecu_pkg.sv */
// Shared types and constants of the performance event counter unit.
package pecu_pkg;

    localparam int NUM_COUNTERS = 4;
    localparam int DATA_W       = 32;
    localparam int EVENT_W      = 8;
    localparam int SEL_W        = 5;
    localparam int CNT_IDX_W    = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    localparam int CYC_BIT      = 31;
    localparam int CTRL_E_BIT   = 0;
    localparam int CTRL_P_BIT   = 1;
    localparam int CTRL_C_BIT   = 2;
    localparam int N_SHIFT      = 11;

    localparam logic [SEL_W-1:0]  N_MASK    = 5'h1f;
    localparam logic [DATA_W-1:0] IMPL_MASK =
        32'h8000_0000 | ((32'd1 << NUM_COUNTERS) - 32'd1);
    localparam logic [DATA_W-1:0] CTRL_N_FIELD =
        32'(SEL_W'(NUM_COUNTERS) & N_MASK) << N_SHIFT;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        REG_CTRL      = 3'd0,
        REG_ENABLE    = 3'd1,
        REG_OVERFLOW  = 3'd2,
        REG_SELECT    = 3'd3,
        REG_CYCLE     = 3'd4,
        REG_EVT_TYPE  = 3'd5,
        REG_EVT_COUNT = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         reg_index;
        logic [DATA_W-1:0]  write_data;
        logic [EVENT_W-1:0] event_id;
        logic               event_valid;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
    } t_rsp;

endpackage

/* rtl/pecu_core.sv */
// Counter state, register decode and tick update of the performance event counter unit.
module pecu_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  pecu_pkg::t_req i_req,
    output pecu_pkg::t_rsp o_rsp
);
    import pecu_pkg::*;

    logic                r_global_enable, n_global_enable;
    logic [DATA_W-1:0]   r_enable_mask, n_enable_mask;
    logic [DATA_W-1:0]   r_ovf_flags, n_ovf_flags;
    logic [SEL_W-1:0]    r_select, n_select;
    logic [DATA_W-1:0]   r_cycle_count, n_cycle_count;
    logic [DATA_W-1:0]   r_event_counts [NUM_COUNTERS];
    logic [DATA_W-1:0]   n_event_counts [NUM_COUNTERS];
    logic [EVENT_W-1:0]  r_event_types [NUM_COUNTERS];
    logic [EVENT_W-1:0]  n_event_types [NUM_COUNTERS];

    logic                 sel_ok;
    logic [CNT_IDX_W-1:0] sel_idx;

    assign sel_ok  = 32'(r_select) < NUM_COUNTERS;
    assign sel_idx = r_select[CNT_IDX_W-1:0];

    always_comb begin
        n_global_enable = r_global_enable;
        n_enable_mask   = r_enable_mask;
        n_ovf_flags     = r_ovf_flags;
        n_select        = r_select;
        n_cycle_count   = r_cycle_count;
        n_event_counts  = r_event_counts;
        n_event_types   = r_event_types;
        o_rsp           = '0;

        case (i_req.req_type)
            REQ_READ: begin
                unique case (i_req.reg_index)
                    REG_CTRL:      o_rsp.read_data = 32'(r_global_enable) | CTRL_N_FIELD;
                    REG_ENABLE:    o_rsp.read_data = r_enable_mask;
                    REG_OVERFLOW:  o_rsp.read_data = r_ovf_flags;
                    REG_SELECT:    o_rsp.read_data = 32'(r_select);
                    REG_CYCLE:     o_rsp.read_data = r_cycle_count;
                    REG_EVT_TYPE: begin
                        if (sel_ok) begin
                            o_rsp.read_data = 32'(r_event_types[sel_idx]);
                        end else begin
                            o_rsp.access_error = 1'b1;
                        end
                    end
                    REG_EVT_COUNT: begin
                        if (sel_ok) begin
                            o_rsp.read_data = r_event_counts[sel_idx];
                        end else begin
                            o_rsp.access_error = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_WRITE: begin
                unique case (i_req.reg_index)
                    REG_CTRL: begin
                        n_global_enable = i_req.write_data[CTRL_E_BIT];
                        if (i_req.write_data[CTRL_P_BIT]) begin
                            for (int i = 0; i < NUM_COUNTERS; i++) begin
                                n_event_counts[i] = '0;
                            end
                        end
                        if (i_req.write_data[CTRL_C_BIT]) begin
                            n_cycle_count = '0;
                        end
                    end
                    REG_ENABLE:   n_enable_mask = r_enable_mask | (i_req.write_data & IMPL_MASK);
                    REG_OVERFLOW: n_ovf_flags = r_ovf_flags & ~(i_req.write_data & IMPL_MASK);
                    REG_SELECT:   n_select = i_req.write_data[SEL_W-1:0] & N_MASK;
                    REG_CYCLE:    n_cycle_count = i_req.write_data;
                    REG_EVT_TYPE: begin
                        if (sel_ok) begin
                            n_event_types[sel_idx] = i_req.write_data[EVENT_W-1:0];
                        end else begin
                            o_rsp.access_error = 1'b1;
                        end
                    end
                    REG_EVT_COUNT: begin
                        if (sel_ok) begin
                            n_event_counts[sel_idx] = i_req.write_data;
                        end else begin
                            o_rsp.access_error = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            REQ_TICK: begin
                if (r_global_enable) begin
                    if (r_enable_mask[CYC_BIT]) begin
                        n_cycle_count = r_cycle_count + 32'd1;
                        if (n_cycle_count == '0) begin
                            n_ovf_flags[CYC_BIT] = 1'b1;
                        end
                    end
                    if (i_req.event_valid) begin
                        for (int i = 0; i < NUM_COUNTERS; i++) begin
                            if (r_enable_mask[i] && r_event_types[i] == i_req.event_id) begin
                                n_event_counts[i] = r_event_counts[i] + 32'd1;
                                if (n_event_counts[i] == '0) begin
                                    n_ovf_flags[i] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_enable <= 1'b0;
            r_enable_mask   <= '0;
            r_ovf_flags     <= '0;
            r_select        <= '0;
            r_cycle_count   <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_event_counts[i] <= '0;
                r_event_types[i]  <= '0;
            end
        end else if (i_go) begin
            r_global_enable <= n_global_enable;
            r_enable_mask   <= n_enable_mask;
            r_ovf_flags     <= n_ovf_flags;
            r_select        <= n_select;
            r_cycle_count   <= n_cycle_count;
            r_event_counts  <= n_event_counts;
            r_event_types   <= n_event_types;
        end
    end

    // Counter state only moves when an item is processed.
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_go |=> $stable(r_cycle_count) && $stable(r_ovf_flags) && $stable(r_enable_mask))
        else $error("counter state changed without a processed item");

    a_mask_impl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_enable_mask & ~IMPL_MASK) == '0)
        else $error("enable bit set for an unimplemented counter");

    a_ovf_impl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf_flags & ~IMPL_MASK) == '0)
        else $error("overflow flag set for an unimplemented counter");

endmodule

/* rtl/performance_event_counter_unit.sv */
// Top level of the performance event counter unit: input register, counter core, result register.
// Each transfer carries a register read, a register write or one clock tick with an optional
// event, and produces exactly one result transfer. One transfer is accepted every cycle unless
// o_in_stall is high; a request is held in the input register and passes through the counter
// core into the result register. A full input register is held only while the result register
// is occupied and stalled, and the counter state is updated in the same cycle as the item's
// result is registered, so every access sees all earlier ticks.
module performance_event_counter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_req_type,
    input  logic [2:0]                       i_reg_index,
    input  logic [pecu_pkg::DATA_W-1:0]      i_write_data,
    input  logic [pecu_pkg::EVENT_W-1:0]     i_event_id,
    input  logic                             i_event_valid,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [pecu_pkg::DATA_W-1:0]      o_read_data,
    output logic                             o_access_error
);
    import pecu_pkg::*;

    logic  r_in_valid;
    t_req  r_in_req;
    logic  r_out_valid;
    t_rsp  r_out_rsp;
    t_rsp  core_rsp;
    logic  out_free;
    logic  go;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_req <= '{req_type:    i_req_type,
                          reg_index:   i_reg_index,
                          write_data:  i_write_data,
                          event_id:    i_event_id,
                          event_valid: i_event_valid};
        end
    end

    pecu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_req   (r_in_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rsp.read_data;
    assign o_access_error = r_out_rsp.access_error;

    // A processed item always lands in the result register.
    a_go_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> o_out_valid)
        else $error("processed item produced no result");

    // An access error never comes with read data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_access_error) |-> (o_read_data == '0))
        else $error("access error with non-zero read data");

    // The input side is only held back by a stalled, occupied result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

endmodule
